// ----- design/chts_pkg.sv -----
package chts_pkg;

    localparam int DEF_NUM_BUCKETS = 64;
    localparam int DEF_SLOTS       = 8;
    localparam int DEF_KEY_BITS    = 31;
    localparam int CFG_RESET       = 64;

    localparam int CMD_W   = 2;
    localparam int ST_W    = 2;
    localparam int CFG_W   = 7;
    localparam int PROBE_W = 4;
    localparam int TOTAL_W = 10;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_SPARE  = 2'd3
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_CALC
    } state_t;

    typedef struct packed {
        status_t status;
        logic    wr;
        logic    inc;
        logic    dec;
    } op_res_t;

endpackage

// ----- design/chts_req_if.sv -----
interface chts_req_if
    import chts_pkg::*;
#(
    parameter int KEY_BITS = DEF_KEY_BITS
);
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [KEY_BITS-1:0] key;

    modport source (output valid, output cmd, output key, input ready);
    modport sink   (input valid, input cmd, input key, output ready);
endinterface

// ----- design/chts_rsp_if.sv -----
interface chts_rsp_if
    import chts_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [ST_W-1:0]    status;
    logic [PROBE_W-1:0] probe_count;
    logic [TOTAL_W-1:0] total_entries;

    modport source (output valid, output status, output probe_count, output total_entries,
                    input ready);
    modport sink   (input valid, input status, input probe_count, input total_entries,
                    output ready);
endinterface

// ----- design/chts_cfg_if.sv -----
interface chts_cfg_if
    import chts_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/chts_mod.sv -----
module chts_mod
    import chts_pkg::*;
#(
    parameter int KEY_BITS = DEF_KEY_BITS,
    parameter int BC_W     = 7
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [KEY_BITS-1:0] key,
    input  logic [BC_W-1:0]     div,
    output logic                done,
    output logic [BC_W-1:0]     rem
);
    localparam int CW = $clog2(KEY_BITS + 1);

    logic [KEY_BITS-1:0] sh_reg, sh_next;
    logic [BC_W-1:0]     rem_reg, rem_next;
    logic [BC_W-1:0]     div_reg, div_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [BC_W:0]       trial;

    always_comb
    begin
        trial     = {rem_reg, sh_reg[KEY_BITS-1]};
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            sh_next  = key;
            rem_next = '0;
            div_next = div;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                trial = trial - {1'b0, div_reg};
            end
            rem_next = trial[BC_W-1:0];
            sh_next  = sh_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(KEY_BITS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;
endmodule

// ----- design/chts_row_mem.sv -----
module chts_row_mem
    import chts_pkg::*;
#(
    parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
    parameter int SLOTS       = DEF_SLOTS,
    parameter int KEY_BITS    = DEF_KEY_BITS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           we,
    input  logic [((NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1)-1:0] waddr,
    input  logic [SLOTS-1:0][KEY_BITS-1:0] wkeys,
    input  logic [$clog2(SLOTS+1)-1:0]     wfill,
    input  logic                           re,
    input  logic [((NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1)-1:0] raddr,
    output logic [SLOTS-1:0][KEY_BITS-1:0] rkeys,
    output logic [$clog2(SLOTS+1)-1:0]     rfill
);
    localparam int FW = $clog2(SLOTS + 1);
    localparam int RW = SLOTS * KEY_BITS + FW;

    logic [RW-1:0]          mem_ram [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] vld_reg;
    logic [RW-1:0]          rd_reg;
    logic                   rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_ram[waddr] <= {wkeys, wfill};
        end
        if (re)
        begin
            rd_reg <= mem_ram[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_vld_reg <= vld_reg[raddr];
            end
        end
    end

    assign rkeys = rd_reg[RW-1:FW];
    assign rfill = rd_vld_reg ? rd_reg[FW-1:0] : '0;
endmodule

// ----- design/chts_row_op.sv -----
module chts_row_op
    import chts_pkg::*;
#(
    parameter int SLOTS    = DEF_SLOTS,
    parameter int KEY_BITS = DEF_KEY_BITS
)
(
    input  logic [CMD_W-1:0]               cmd,
    input  logic [KEY_BITS-1:0]            key,
    input  logic [SLOTS-1:0][KEY_BITS-1:0] keys,
    input  logic [$clog2(SLOTS+1)-1:0]     fill,
    output logic [SLOTS-1:0][KEY_BITS-1:0] new_keys,
    output logic [$clog2(SLOTS+1)-1:0]     new_fill,
    output logic [$clog2(SLOTS+1)-1:0]     probes,
    output op_res_t                        res
);
    localparam int FW = $clog2(SLOTS + 1);

    always_comb
    begin
        logic [FW-1:0] ins_pos;
        logic [FW-1:0] eq_pos;
        logic          found;
        ins_pos = fill;
        eq_pos  = fill;
        found   = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (FW'(i) < fill && !(keys[i] < key))
            begin
                ins_pos = FW'(i);
            end
            if (FW'(i) < fill && keys[i] == key)
            begin
                eq_pos = FW'(i);
                found  = 1'b1;
            end
        end

        new_keys = keys;
        new_fill = fill;
        probes   = '0;
        res      = '{status: ST_OK, wr: 1'b0, inc: 1'b0, dec: 1'b0};

        case (cmd)
            CMD_INSERT:
            begin
                if (fill >= FW'(SLOTS))
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    for (int i = 1; i < SLOTS; i++)
                    begin
                        if (FW'(i) > ins_pos)
                        begin
                            new_keys[i] = keys[i-1];
                        end
                    end
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (FW'(i) == ins_pos)
                        begin
                            new_keys[i] = key;
                        end
                    end
                    new_fill = fill + 1'b1;
                    res.wr   = 1'b1;
                    res.inc  = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (!found)
                begin
                    res.status = ST_MISSING;
                end
                else
                begin
                    for (int i = 0; i < SLOTS - 1; i++)
                    begin
                        if (FW'(i) >= eq_pos)
                        begin
                            new_keys[i] = keys[i+1];
                        end
                    end
                    new_fill = fill - 1'b1;
                    res.wr   = 1'b1;
                    res.dec  = 1'b1;
                end
            end
            CMD_SEARCH:
            begin
                if (found)
                begin
                    probes = eq_pos + 1'b1;
                end
                else
                begin
                    res.status = ST_MISSING;
                    probes     = fill;
                end
            end
            default:
            begin
                res.status = ST_OK;
            end
        endcase
    end
endmodule

// ----- design/chained_hash_table_sorted.sv -----
// Each request runs in order through a bit-serial modulo of the key by bucket_count,
// a registered row read of that bucket and an update step that loads the response register.
// A new request is taken only while idle, once the previous one is in the response register.
// A finished response may wait in its output register while the next request runs.
// Reset (rst_n, async, active low) empties every bucket and sets bucket_count to 64 (capped at NUM_BUCKETS).
module chained_hash_table_sorted
    import chts_pkg::*;
#(
    parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
    parameter int SLOTS       = DEF_SLOTS,
    parameter int KEY_BITS    = DEF_KEY_BITS
)
(
    input logic        clk,
    input logic        rst_n,
    chts_req_if.sink   req,
    chts_rsp_if.source rsp,
    chts_cfg_if.sink   cfg
);
    localparam int BC_W = $clog2(NUM_BUCKETS + 1);
    localparam int BI_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int FW   = $clog2(SLOTS + 1);
    localparam int TW   = $clog2(NUM_BUCKETS * SLOTS + 1);
    localparam int BC_RESET = (CFG_RESET > NUM_BUCKETS) ? NUM_BUCKETS : CFG_RESET;

    state_t                     state_reg, state_next;
    logic [BC_W-1:0]            bc_reg, bc_next;
    logic [TW-1:0]              total_reg, total_next;
    logic [CMD_W-1:0]           cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]        key_reg, key_next;
    logic [BI_W-1:0]            bkt_reg, bkt_next;
    logic                       rsp_vld_reg, rsp_vld_next;
    logic [ST_W-1:0]            st_reg, st_next;
    logic [PROBE_W-1:0]         pr_reg, pr_next;
    logic [TOTAL_W-1:0]         tot_reg, tot_next;

    logic                       acc;
    logic                       mod_done;
    logic [BC_W-1:0]            mod_rem;
    logic                       mem_we;
    logic [SLOTS-1:0][KEY_BITS-1:0] rd_keys, wr_keys;
    logic [FW-1:0]              rd_fill, wr_fill, probes;
    op_res_t                    res;

    assign req.ready = (state_reg == S_IDLE);
    assign acc       = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        logic [31:0] v;
        v = 32'(cfg.data);
        bc_next = bc_reg;
        if (cfg.valid)
        begin
            if (v == 32'd0)
            begin
                bc_next = BC_W'(1);
            end
            else if (v > 32'(NUM_BUCKETS))
            begin
                bc_next = BC_W'(NUM_BUCKETS);
            end
            else
            begin
                bc_next = BC_W'(v);
            end
        end
    end

    chts_mod #(.KEY_BITS(KEY_BITS), .BC_W(BC_W)) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (acc),
        .key   (req.key),
        .div   (bc_reg),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    chts_row_mem #(.NUM_BUCKETS(NUM_BUCKETS), .SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (bkt_reg),
        .wkeys (wr_keys),
        .wfill (wr_fill),
        .re    (mod_done),
        .raddr (BI_W'(mod_rem)),
        .rkeys (rd_keys),
        .rfill (rd_fill)
    );

    chts_row_op #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_op (
        .cmd      (cmd_reg),
        .key      (key_reg),
        .keys     (rd_keys),
        .fill     (rd_fill),
        .new_keys (wr_keys),
        .new_fill (wr_fill),
        .probes   (probes),
        .res      (res)
    );

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        bkt_next     = bkt_reg;
        total_next   = total_reg;
        rsp_vld_next = rsp_vld_reg;
        st_next      = st_reg;
        pr_next      = pr_reg;
        tot_next     = tot_reg;
        mem_we       = 1'b0;

        if (rsp.valid && rsp.ready)
        begin
            rsp_vld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    cmd_next   = req.cmd;
                    key_next   = req.key;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    bkt_next   = BI_W'(mod_rem);
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (!rsp_vld_reg || rsp.ready)
                begin
                    mem_we = res.wr;
                    if (res.inc)
                    begin
                        total_next = total_reg + 1'b1;
                    end
                    else if (res.dec)
                    begin
                        total_next = total_reg - 1'b1;
                    end
                    rsp_vld_next = 1'b1;
                    st_next      = res.status;
                    pr_next      = PROBE_W'(probes);
                    tot_next     = TOTAL_W'(total_next);
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bc_reg      <= BC_W'(BC_RESET);
            total_reg   <= '0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bc_reg      <= bc_next;
            total_reg   <= total_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        key_reg <= key_next;
        bkt_reg <= bkt_next;
        st_reg  <= st_next;
        pr_reg  <= pr_next;
        tot_reg <= tot_next;
    end

    assign rsp.valid         = rsp_vld_reg;
    assign rsp.status        = st_reg;
    assign rsp.probe_count   = pr_reg;
    assign rsp.total_entries = tot_reg;

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> mod_rem < bc_reg)
        else $error("bucket index out of range");

    a_we_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == S_CALC)
        else $error("row write outside update cycle");

    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(total_reg) |-> (total_reg == $past(total_reg) + 1'b1 ||
                                 total_reg == $past(total_reg) - 1'b1))
        else $error("entry count jumped");

    a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TW'(NUM_BUCKETS * SLOTS))
        else $error("entry count above capacity");
endmodule

// ----- dv/tb_chained_hash_table_sorted.sv -----
`timescale 1ns / 100ps

module tb_chained_hash_table_sorted;
    import chts_pkg::*;

    localparam int NB = DEF_NUM_BUCKETS;
    localparam int NS = DEF_SLOTS;
    localparam int KB = DEF_KEY_BITS;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [KB-1:0]    key;
    } request_t;

    typedef struct {
        logic [ST_W-1:0]    status;
        logic [PROBE_W-1:0] probes;
        logic [TOTAL_W-1:0] total;
    } response_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    chts_req_if #(.KEY_BITS(KB)) req_ch ();
    chts_rsp_if rsp_ch ();
    chts_cfg_if cfg_ch ();

    chained_hash_table_sorted #(.NUM_BUCKETS(NB), .SLOTS(NS), .KEY_BITS(KB)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    always #1 clk = ~clk;

    // shadow table
    logic [KB-1:0] shadow_keys [NB][NS];
    int            shadow_fill [NB];
    int            shadow_total;
    int            shadow_buckets;

    request_t  pending_reqs [$];
    response_t expected_rsps [$];
    int        error_count;
    int        cycle_count;
    bit        hold_off;
    int        hold_cycles;
    int        rsp_gap;
    int        req_gap;
    bit        cfg_pending;
    logic [CFG_W-1:0] cfg_value;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic response_t apply_op(request_t rq);
        response_t res;
        int b;
        int fill;
        int pos;
        b = int'(rq.key % shadow_buckets);
        fill = shadow_fill[b];
        res.status = ST_OK;
        res.probes = '0;
        pos = 0;
        case (rq.cmd)
            CMD_INSERT:
            begin
                if (fill >= NS)
                    res.status = ST_FULL;
                else
                begin
                    while (pos < fill && shadow_keys[b][pos] < rq.key) pos++;
                    for (int i = fill; i > pos; i--) shadow_keys[b][i] = shadow_keys[b][i-1];
                    shadow_keys[b][pos] = rq.key;
                    shadow_fill[b] = fill + 1;
                    shadow_total++;
                end
            end
            CMD_REMOVE:
            begin
                while (pos < fill && shadow_keys[b][pos] != rq.key) pos++;
                if (pos >= fill)
                    res.status = ST_MISSING;
                else
                begin
                    for (int i = pos; i + 1 < fill; i++) shadow_keys[b][i] = shadow_keys[b][i+1];
                    shadow_fill[b] = fill - 1;
                    if (shadow_total > 0) shadow_total--;
                end
            end
            CMD_SEARCH:
            begin
                while (pos < fill && shadow_keys[b][pos] != rq.key) pos++;
                if (pos >= fill)
                begin
                    res.status = ST_MISSING;
                    res.probes = PROBE_W'(fill);
                end
                else
                    res.probes = PROBE_W'(pos + 1);
            end
            default: ;
        endcase
        res.total = TOTAL_W'(shadow_total);
        return res;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                request_t rq;
                rq.cmd = req_ch.cmd;
                rq.key = req_ch.key;
                expected_rsps.push_back(apply_op(rq));
            end
            if (cfg_ch.valid && cfg_ch.ready)
                cfg_ch.valid <= 1'b0;
            else if (cfg_pending && !cfg_ch.valid)
            begin
                cfg_ch.valid <= 1'b1;
                cfg_ch.data  <= cfg_value;
                cfg_pending  <= 1'b0;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_gap > 0)
                begin
                    req_gap <= req_gap - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    request_t nx;
                    nx = pending_reqs.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.cmd   <= nx.cmd;
                    req_ch.key   <= nx.key;
                    req_gap <= rand_gap();
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cycles > 0)
                hold_cycles <= hold_cycles - 1;
            else if (hold_off)
            begin
                hold_off    <= 1'b0;
                hold_cycles <= 400;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected response transaction");
                    error_count++;
                end
                else
                begin
                    response_t ex;
                    ex = expected_rsps.pop_front();
                    if (rsp_ch.status !== ex.status)
                    begin
                        $error("status exp %0d act %0d", ex.status, rsp_ch.status);
                        error_count++;
                    end
                    if (rsp_ch.probe_count !== ex.probes)
                    begin
                        $error("probe_count exp %0d act %0d", ex.probes, rsp_ch.probe_count);
                        error_count++;
                    end
                    if (rsp_ch.total_entries !== ex.total)
                    begin
                        $error("total_entries exp %0d act %0d", ex.total,
                               rsp_ch.total_entries);
                        error_count++;
                    end
                end
            end
            if (hold_cycles > 0 || hold_off)
            begin
                rsp_ch.ready <= 1'b0;
            end
            else if (rsp_gap > 0)
            begin
                rsp_gap <= rsp_gap - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) rsp_gap <= rand_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic add_req(logic [CMD_W-1:0] c, logic [KB-1:0] k);
        request_t rq;
        rq.cmd = c;
        rq.key = k;
        pending_reqs.push_back(rq);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (3 * (KB + 3)) @(posedge clk);
    endtask

    task automatic set_buckets(logic [CFG_W-1:0] v);
        int n;
        cfg_value = v;
        cfg_pending = 1'b1;
        @(posedge clk);
        while (cfg_pending || cfg_ch.valid) @(posedge clk);
        n = v;
        if (n == 0) n = 1;
        if (n > NB) n = NB;
        shadow_buckets = n;
    endtask

    task automatic random_phase(int count, int key_span);
        int r;
        logic [KB-1:0] k;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 10) k = KB'($urandom());
            else k = KB'($urandom_range(0, key_span));
            r = $urandom_range(0, 99);
            if (r < 45) add_req(CMD_INSERT, k);
            else if (r < 70) add_req(CMD_REMOVE, k);
            else if (r < 97) add_req(CMD_SEARCH, k);
            else add_req(CMD_SPARE, k);
        end
    endtask

    initial
    begin
        for (int b = 0; b < NB; b++) shadow_fill[b] = 0;
        shadow_total = 0;
        shadow_buckets = CFG_RESET;
        error_count = 0;
        cycle_count = 0;
        hold_off = 1'b0;
        hold_cycles = 0;
        rsp_gap = 0;
        req_gap = 0;
        cfg_pending = 1'b0;
        cfg_value = '0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_INSERT;
        req_ch.key = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, fill one bucket past capacity, misses, unused code
        add_req(CMD_SEARCH, '0);
        add_req(CMD_REMOVE, 31'd5);
        add_req(CMD_INSERT, {KB{1'b1}});
        add_req(CMD_SEARCH, {KB{1'b1}});
        add_req(CMD_INSERT, '0);
        add_req(CMD_INSERT, 31'h2AAA_AAAA);
        add_req(CMD_INSERT, 31'h5555_5555);
        for (int i = 8; i >= 0; i--) add_req(CMD_INSERT, 31'(i * 64 + 3));
        add_req(CMD_INSERT, 31'(3));
        add_req(CMD_SEARCH, 31'(7 * 64 + 3));
        add_req(CMD_SEARCH, 31'(1000 * 64 + 3));
        add_req(CMD_REMOVE, 31'(3));
        add_req(CMD_REMOVE, 31'(3));
        add_req(CMD_SPARE, 31'd9);
        add_req(CMD_REMOVE, '0);
        drain();

        // bucket count zero is treated as one
        set_buckets('0);
        random_phase(100, 40);
        drain();
        set_buckets(7'h7F);
        hold_off = 1'b1;
        random_phase(160, 600);
        drain();
        set_buckets(7'd1);
        random_phase(80, 30);
        drain();
        set_buckets(7'd64);
        random_phase(160, 2000);
        drain();
        set_buckets(7'd5);
        random_phase(130, 100);
        drain();
        set_buckets(7'd37);
        random_phase(120, 500);
        drain();

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
